// ===== hdl/cld_pkg.sv =====
// Shared types and constants for the camera line capture decimator.
// Holds the transaction structs, event codes, register indexes and limits.
// Depends on nothing; used by camera_line_capture_decimator and its testbench.
`timescale 1ns / 1ps

package cld_pkg;

    // Field widths of the transactions.
    localparam int PIXEL_W = 12;
    localparam int ROW_W   = 6;
    localparam int COL_W   = 8;

    // Storage limits of the frame store.
    localparam logic [6:0] MAX_ROWS = 7'd64;
    localparam logic [8:0] MAX_COLS = 9'd256;

    // Saturation points.
    localparam logic [9:0] SRC_ROW_MAX = 10'd1023;
    localparam logic [7:0] FPS_MAX     = 8'd255;

    // Register reset values.
    localparam logic [9:0]  START_ROW_RST    = 10'd0;
    localparam logic [7:0]  ROW_STEP_RST     = 8'd1;
    localparam logic [6:0]  ROWS_TO_KEEP_RST = 7'd64;
    localparam logic [8:0]  COLS_PER_ROW_RST = 9'd256;
    localparam logic [15:0] TICKS_PER_SEC_RST = 16'd1000;

    // Register indexes (byte address divided by four).
    localparam logic [2:0] REG_START_ROW    = 3'd0;
    localparam logic [2:0] REG_ROW_STEP     = 3'd1;
    localparam logic [2:0] REG_ROWS_TO_KEEP = 3'd2;
    localparam logic [2:0] REG_COLS_PER_ROW = 3'd3;
    localparam logic [2:0] REG_TICKS_PER_SEC = 3'd4;

    // Event kinds carried by an input transaction.
    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_VSYNC = 2'd1,
        CMD_HSYNC = 2'd2,
        CMD_PIXEL = 2'd3
    } cld_cmd_t;

    typedef struct packed {
        cld_cmd_t             cmd;
        logic [PIXEL_W-1:0]   pixel_value;
    } cld_in_t;

    typedef struct packed {
        logic                 write_valid;
        logic [ROW_W-1:0]     write_row;
        logic [COL_W-1:0]     write_col;
        logic [PIXEL_W-1:0]   pixel_out;
        logic                 line_done;
        logic                 frame_full;
        logic [7:0]           fps_value;
        logic [7:0]           fps_peak;
        logic [15:0]          seconds_count;
        logic [15:0]          frame_number;
    } cld_out_t;

endpackage

// ===== hdl/camera_line_capture_decimator.sv =====
// Camera line capture decimator: row-decimating line capture and frame-rate meter.
// Single module with an APB register port; depends on cld_pkg.
`timescale 1ns / 1ps

// The block takes one event transaction (tick, vertical sync, horizontal sync
// or pixel sample) per clock cycle while the result channel is not stalled,
// and returns exactly one result transaction for each. An event is held in an
// input register; once the result register is empty or being drained, its
// state update and result are computed combinationally into the result
// register, together with the update of the capture and frame-rate counters.
// The input register keeps taking one more transaction while a result waits
// downstream. Pixel samples become frame-store writes at (kept row, column)
// only while a line is being captured; the last five result fields always
// show the state after the event. Configure the five registers (start row,
// row step, rows to keep, columns per row, ticks per second) at byte
// addresses 0, 4, 8, 12 and 16 while no transaction is in flight.
module camera_line_capture_decimator (
    input  logic              aclk,
    input  logic              aresetn,
    // Event input channel
    input  logic              s_valid,
    output logic              s_ready,
    input  cld_pkg::cld_in_t  s_item,
    // Result output channel
    output logic              m_valid,
    input  logic              m_ready,
    output cld_pkg::cld_out_t m_item,
    // Configuration port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [4:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    import cld_pkg::*;

    // Configuration registers.
    logic [9:0]  start_row_reg;
    logic [7:0]  row_step_reg;
    logic [6:0]  rows_to_keep_reg;
    logic [8:0]  cols_per_row_reg;
    logic [15:0] ticks_per_sec_reg;

    // Handshake stages.
    logic        in_valid_reg;
    cld_in_t     in_item_reg;
    logic        m_valid_reg;
    cld_out_t    m_item_reg;
    cld_out_t    m_item_next;
    logic        advance;

    // Capture and measurement state.
    logic [15:0] tick_counter_reg,  tick_counter_next;
    logic [15:0] second_counter_reg, second_counter_next;
    logic [7:0]  frames_sec_reg,    frames_sec_next;
    logic [7:0]  latched_fps_reg,   latched_fps_next;
    logic [7:0]  peak_fps_reg,      peak_fps_next;
    logic [15:0] frame_counter_reg, frame_counter_next;
    logic [9:0]  source_row_reg,    source_row_next;
    logic [7:0]  step_phase_reg,    step_phase_next;
    logic [6:0]  kept_rows_reg,     kept_rows_next;
    logic [8:0]  column_index_reg,  column_index_next;
    logic        capturing_reg,     capturing_next;

    // Derived limits and helpers.
    logic [6:0]  row_limit;
    logic [8:0]  col_limit;
    logic [7:0]  step_eff;
    logic [7:0]  phase_base;
    logic [8:0]  phase_inc;
    logic [15:0] tick_inc;
    logic [8:0]  col_inc;
    logic [2:0]  reg_index;
    logic        cfg_write;

    assign pready    = 1'b1;
    assign reg_index = paddr[4:2];
    assign cfg_write = psel && penable && pwrite && pready;

    // Configuration register writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_row_reg     <= START_ROW_RST;
            row_step_reg      <= ROW_STEP_RST;
            rows_to_keep_reg  <= ROWS_TO_KEEP_RST;
            cols_per_row_reg  <= COLS_PER_ROW_RST;
            ticks_per_sec_reg <= TICKS_PER_SEC_RST;
        end else if (cfg_write) begin
            case (reg_index)
                REG_START_ROW:     start_row_reg     <= pwdata[9:0];
                REG_ROW_STEP:      row_step_reg      <= pwdata[7:0];
                REG_ROWS_TO_KEEP:  rows_to_keep_reg  <= pwdata[6:0];
                REG_COLS_PER_ROW:  cols_per_row_reg  <= pwdata[8:0];
                REG_TICKS_PER_SEC: ticks_per_sec_reg <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // Register read-back.
    always_comb begin
        case (reg_index)
            REG_START_ROW:     prdata = {22'd0, start_row_reg};
            REG_ROW_STEP:      prdata = {24'd0, row_step_reg};
            REG_ROWS_TO_KEEP:  prdata = {25'd0, rows_to_keep_reg};
            REG_COLS_PER_ROW:  prdata = {23'd0, cols_per_row_reg};
            REG_TICKS_PER_SEC: prdata = {16'd0, ticks_per_sec_reg};
            default:           prdata = 32'd0;
        endcase
    end

    // An item moves from the input register into the result register when the
    // result register is empty or is being drained in this cycle.
    assign advance = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_item_reg <= s_item;
        end
        if (advance) begin
            m_item_reg <= m_item_next;
        end
    end

    // Effective limits: the smaller of the register and the store size.
    assign row_limit = (rows_to_keep_reg < MAX_ROWS) ? rows_to_keep_reg : MAX_ROWS;
    assign col_limit = (cols_per_row_reg < MAX_COLS) ? cols_per_row_reg : MAX_COLS;
    assign step_eff  = (row_step_reg == 8'd0) ? 8'd1 : row_step_reg;

    // The phase returns to zero if the step was lowered to or below it.
    assign phase_base = (step_phase_reg >= step_eff) ? 8'd0 : step_phase_reg;
    assign phase_inc  = {1'b0, phase_base} + 9'd1;
    assign tick_inc   = tick_counter_reg + 16'd1;
    assign col_inc    = column_index_reg + 9'd1;

    // Event processing: next state and the result of the held transaction.
    always_comb begin
        tick_counter_next   = tick_counter_reg;
        second_counter_next = second_counter_reg;
        frames_sec_next     = frames_sec_reg;
        latched_fps_next    = latched_fps_reg;
        peak_fps_next       = peak_fps_reg;
        frame_counter_next  = frame_counter_reg;
        source_row_next     = source_row_reg;
        step_phase_next     = step_phase_reg;
        kept_rows_next      = kept_rows_reg;
        column_index_next   = column_index_reg;
        capturing_next      = capturing_reg;

        m_item_next             = '0;

        case (in_item_reg.cmd)
            CMD_TICK: begin
                tick_counter_next = tick_inc;
                if (tick_inc >= ticks_per_sec_reg) begin
                    tick_counter_next   = 16'd0;
                    second_counter_next = second_counter_reg + 16'd1;
                    latched_fps_next    = frames_sec_reg;
                    frames_sec_next     = 8'd0;
                    if (frames_sec_reg > peak_fps_reg) begin
                        peak_fps_next = frames_sec_reg;
                    end
                end
            end
            CMD_VSYNC: begin
                frame_counter_next = frame_counter_reg + 16'd1;
                if (frames_sec_reg < FPS_MAX) begin
                    frames_sec_next = frames_sec_reg + 8'd1;
                end
                source_row_next   = 10'd0;
                step_phase_next   = 8'd0;
                kept_rows_next    = 7'd0;
                column_index_next = 9'd0;
                capturing_next    = 1'b0;
            end
            CMD_HSYNC: begin
                capturing_next  = 1'b0;
                step_phase_next = phase_base;
                if (source_row_reg >= start_row_reg) begin
                    if ((phase_base == 8'd0) && (kept_rows_reg < row_limit) &&
                        (col_limit != 9'd0)) begin
                        capturing_next    = 1'b1;
                        column_index_next = 9'd0;
                    end
                    step_phase_next = (phase_inc >= {1'b0, step_eff}) ? 8'd0
                                                                      : phase_inc[7:0];
                end
                if (source_row_reg < SRC_ROW_MAX) begin
                    source_row_next = source_row_reg + 10'd1;
                end
            end
            CMD_PIXEL: begin
                if (capturing_reg && (column_index_reg < col_limit)) begin
                    m_item_next.write_valid = 1'b1;
                    m_item_next.write_row   = kept_rows_reg[ROW_W-1:0];
                    m_item_next.write_col   = column_index_reg[COL_W-1:0];
                    m_item_next.pixel_out   = in_item_reg.pixel_value;
                    column_index_next       = col_inc;
                    if (col_inc >= col_limit) begin
                        m_item_next.line_done = 1'b1;
                        kept_rows_next        = kept_rows_reg + 7'd1;
                        capturing_next        = 1'b0;
                    end
                end else begin
                    capturing_next = 1'b0;
                end
            end
            default: ;
        endcase

        // Status fields show the state after the event.
        m_item_next.frame_full    = (kept_rows_next >= row_limit);
        m_item_next.fps_value     = latched_fps_next;
        m_item_next.fps_peak      = peak_fps_next;
        m_item_next.seconds_count = second_counter_next;
        m_item_next.frame_number  = frame_counter_next;
    end

    // State update as each transaction is processed.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_counter_reg   <= 16'd0;
            second_counter_reg <= 16'd0;
            frames_sec_reg     <= 8'd0;
            latched_fps_reg    <= 8'd0;
            peak_fps_reg       <= 8'd0;
            frame_counter_reg  <= 16'd0;
            source_row_reg     <= 10'd0;
            step_phase_reg     <= 8'd0;
            kept_rows_reg      <= 7'd0;
            column_index_reg   <= 9'd0;
            capturing_reg      <= 1'b0;
        end else if (advance) begin
            tick_counter_reg   <= tick_counter_next;
            second_counter_reg <= second_counter_next;
            frames_sec_reg     <= frames_sec_next;
            latched_fps_reg    <= latched_fps_next;
            peak_fps_reg       <= peak_fps_next;
            frame_counter_reg  <= frame_counter_next;
            source_row_reg     <= source_row_next;
            step_phase_reg     <= step_phase_next;
            kept_rows_reg      <= kept_rows_next;
            column_index_reg   <= column_index_next;
            capturing_reg      <= capturing_next;
        end
    end

    // A completed line is always reported on a pixel write.
    a_line_done_write: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_item_reg.line_done |-> m_item_reg.write_valid)
        else $error("line_done without a pixel write");

    // A pixel that arrives while idle never produces a write.
    a_idle_pixel: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && (in_item_reg.cmd == CMD_PIXEL) && !capturing_reg
        |=> !m_item_reg.write_valid)
        else $error("write issued while not capturing");

    // Seconds advance only on a tick.
    a_seconds_on_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && (in_item_reg.cmd != CMD_TICK) |=> $stable(second_counter_reg))
        else $error("seconds changed on a non-tick event");

    // The source row only moves backward on a vertical sync.
    a_source_row_mono: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && (in_item_reg.cmd != CMD_VSYNC)
        |=> source_row_reg >= $past(source_row_reg))
        else $error("source row went backward without a vertical sync");

    // The peak frame rate never falls below the latched rate.
    a_peak_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        peak_fps_reg >= latched_fps_reg)
        else $error("peak frame rate below latched frame rate");

endmodule

// ===== tb/camera_line_capture_decimator_tb.sv =====
// Self-checking testbench for camera_line_capture_decimator.
// Drives event transactions and APB writes, and predicts every result in a scoreboard class.
// Depends on cld_pkg and the camera_line_capture_decimator RTL.
`timescale 1ns / 1ps

module camera_line_capture_decimator_tb;
    import cld_pkg::*;

    // Line capture and frame-rate predictor with its queue of expected results.
    class capture_scoreboard;
        // Copy of the configuration registers.
        logic [9:0]  start_row;
        logic [7:0]  row_step;
        logic [6:0]  rows_to_keep;
        logic [8:0]  cols_per_row;
        logic [15:0] ticks_per_sec;
        // Predicted block state.
        logic [15:0] tick_cnt;
        logic [15:0] sec_cnt;
        logic [7:0]  frames_in_sec;
        logic [7:0]  fps_latched;
        logic [7:0]  fps_max;
        logic [15:0] frame_cnt;
        logic [9:0]  src_row;
        logic [7:0]  step_phase;
        logic [6:0]  kept;
        logic [8:0]  col;
        logic        capturing;
        cld_out_t    expected_q[$];
        int          errors;

        function new();
            start_row     = START_ROW_RST;
            row_step      = ROW_STEP_RST;
            rows_to_keep  = ROWS_TO_KEEP_RST;
            cols_per_row  = COLS_PER_ROW_RST;
            ticks_per_sec = TICKS_PER_SEC_RST;
            tick_cnt      = '0;
            sec_cnt       = '0;
            frames_in_sec = '0;
            fps_latched   = '0;
            fps_max       = '0;
            frame_cnt     = '0;
            src_row       = '0;
            step_phase    = '0;
            kept          = '0;
            col           = '0;
            capturing     = 1'b0;
            errors        = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [31:0] val);
            case (idx)
                REG_START_ROW:     start_row     = val[9:0];
                REG_ROW_STEP:      row_step      = val[7:0];
                REG_ROWS_TO_KEEP:  rows_to_keep  = val[6:0];
                REG_COLS_PER_ROW:  cols_per_row  = val[8:0];
                REG_TICKS_PER_SEC: ticks_per_sec = val[15:0];
                default: ;
            endcase
        endfunction

        function int row_limit();
            return (rows_to_keep < MAX_ROWS) ? int'(rows_to_keep) : int'(MAX_ROWS);
        endfunction

        function int col_limit();
            return (cols_per_row < MAX_COLS) ? int'(cols_per_row) : int'(MAX_COLS);
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // Advance the predicted state by one accepted event and queue its result.
        function void note_event(cld_in_t ev);
            int       step_eff;
            int       rlim;
            int       clim;
            cld_out_t r;
            r    = '0;
            rlim = row_limit();
            clim = col_limit();
            case (ev.cmd)
                CMD_TICK: begin
                    tick_cnt = tick_cnt + 16'd1;
                    if (tick_cnt >= ticks_per_sec) begin
                        sec_cnt       = sec_cnt + 16'd1;
                        tick_cnt      = '0;
                        fps_latched   = frames_in_sec;
                        frames_in_sec = '0;
                        if (fps_latched > fps_max)
                            fps_max = fps_latched;
                    end
                end
                CMD_VSYNC: begin
                    frame_cnt = frame_cnt + 16'd1;
                    if (frames_in_sec < FPS_MAX)
                        frames_in_sec = frames_in_sec + 8'd1;
                    src_row    = '0;
                    step_phase = '0;
                    kept       = '0;
                    col        = '0;
                    capturing  = 1'b0;
                end
                CMD_HSYNC: begin
                    // A zero step keeps every eligible row.
                    step_eff  = (row_step == 0) ? 1 : int'(row_step);
                    capturing = 1'b0;
                    if (int'(step_phase) >= step_eff)
                        step_phase = '0;
                    if (src_row >= start_row) begin
                        if (step_phase == 0 && int'(kept) < rlim && clim != 0) begin
                            capturing = 1'b1;
                            col       = '0;
                        end
                        step_phase = (int'(step_phase) + 1 >= step_eff) ? 8'd0
                                                                        : step_phase + 8'd1;
                    end
                    if (src_row < SRC_ROW_MAX)
                        src_row = src_row + 10'd1;
                end
                default: begin
                    if (capturing && int'(col) < clim) begin
                        r.write_valid = 1'b1;
                        r.write_row   = kept[5:0];
                        r.write_col   = col[7:0];
                        r.pixel_out   = ev.pixel_value;
                        col           = col + 9'd1;
                        if (int'(col) >= clim) begin
                            r.line_done = 1'b1;
                            kept        = kept + 7'd1;
                            capturing   = 1'b0;
                        end
                    end else begin
                        capturing = 1'b0;
                    end
                end
            endcase
            r.frame_full    = (int'(kept) >= rlim);
            r.fps_value     = fps_latched;
            r.fps_peak      = fps_max;
            r.seconds_count = sec_cnt;
            r.frame_number  = frame_cnt;
            expected_q.push_back(r);
        endfunction

        function void compare_field(string field, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                errors++;
                if (errors <= 60)
                    $display("%0t: %s mismatch: expected %0d, actual %0d",
                             $time, field, want, got);
            end
        endfunction

        // Compare one accepted result against the oldest expectation.
        function void check_result(cld_out_t got);
            cld_out_t want;
            if (expected_q.size() == 0) begin
                errors++;
                if (errors <= 60)
                    $display("%0t: unexpected result transaction, actual %h", $time, got);
                return;
            end
            want = expected_q.pop_front();
            compare_field("write_valid", want.write_valid, got.write_valid);
            compare_field("write_row", want.write_row, got.write_row);
            compare_field("write_col", want.write_col, got.write_col);
            compare_field("pixel_out", want.pixel_out, got.pixel_out);
            compare_field("line_done", want.line_done, got.line_done);
            compare_field("frame_full", want.frame_full, got.frame_full);
            compare_field("fps_value", want.fps_value, got.fps_value);
            compare_field("fps_peak", want.fps_peak, got.fps_peak);
            compare_field("seconds_count", want.seconds_count, got.seconds_count);
            compare_field("frame_number", want.frame_number, got.frame_number);
        endfunction

        function void flag_missing();
            errors++;
            $display("%0t: %0d expected result transactions never arrived: expected 0, actual %0d",
                     $time, expected_q.size(), expected_q.size());
            expected_q.delete();
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    cld_in_t     s_item;
    logic        m_valid;
    logic        m_ready;
    cld_out_t    m_item;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    capture_scoreboard sb;
    int send_idle_pct;
    int recv_stall_pct;
    bit hold_pending;
    int hold_left;

    camera_line_capture_decimator uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Clock generation.
    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // Run limit, far beyond the slowest correct run.
    initial begin
        #5000000;
        $display("camera_line_capture_decimator_tb NOT OK");
        $finish;
    end

    // Monitor both channels on the pre-edge values.
    always @(posedge aclk) begin
        if (aresetn && sb != null) begin
            if (s_valid && s_ready)
                sb.note_event(s_item);
            if (m_valid && m_ready)
                sb.check_result(m_item);
        end
    end

    // Result receiver: random stalls, plus one long hold-off on request.
    initial begin
        m_ready   <= 1'b0;
        hold_left = 0;
        forever begin
            @(posedge aclk);
            if (hold_pending) begin
                hold_pending = 1'b0;
                hold_left    = 60;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    task automatic set_idling(int mode);
        case (mode)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 73; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 73; end
            default: begin send_idle_pct = 14; recv_stall_pct = 14; end
        endcase
    endtask

    // Offer one event transaction and wait until it is accepted.
    task automatic push_event(cld_cmd_t cmd, logic [11:0] pix);
        cld_in_t ev;
        ev.cmd         = cmd;
        ev.pixel_value = pix;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= ev;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
    endtask

    // APB write: setup cycle, access cycle, then the port is released.
    task automatic apb_write(logic [2:0] idx, logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        sb.write_reg(idx, val);
        @(posedge aclk);
    endtask

    task automatic configure_all(int start, int stp, int rows, int cols, int tps);
        apb_write(REG_START_ROW, start);
        apb_write(REG_ROW_STEP, stp);
        apb_write(REG_ROWS_TO_KEEP, rows);
        apb_write(REG_COLS_PER_ROW, cols);
        apb_write(REG_TICKS_PER_SEC, tps);
    endtask

    // Stop offering and wait, with a bound, until every result has come back.
    task automatic wait_idle();
        int n;
        n = 0;
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() > 0 && n < 20000) begin
            @(posedge aclk);
            n++;
        end
        if (sb.pending() > 0)
            sb.flag_missing();
        repeat (4) @(posedge aclk);
    endtask

    // One line: a horizontal sync and its pixel samples, with an occasional tick between.
    task automatic send_line(int n_pix);
        push_event(CMD_HSYNC, $urandom_range(0, 4095));
        for (int i = 0; i < n_pix; i++) begin
            if ($urandom_range(0, 99) < 8)
                push_event(CMD_TICK, $urandom_range(0, 4095));
            push_event(CMD_PIXEL, $urandom_range(0, 4095));
        end
    endtask

    // Mostly well-formed frames and lines, with some ticks and random noise.
    task automatic run_random_phase(int n_items);
        int sent;
        int pick;
        int len;
        int clim;
        sent = 0;
        while (sent < n_items) begin
            pick = $urandom_range(0, 99);
            clim = sb.col_limit();
            if (pick < 8) begin
                push_event(CMD_VSYNC, $urandom_range(0, 4095));
                sent++;
            end else if (pick < 72) begin
                len  = (clim == 0) ? $urandom_range(1, 3) : clim;
                pick = $urandom_range(0, 9);
                if (pick == 0 && len > 0)
                    len--;
                else if (pick == 1)
                    len++;
                send_line(len);
                sent += len + 1;
            end else if (pick < 88) begin
                push_event(CMD_TICK, $urandom_range(0, 4095));
                sent++;
            end else begin
                push_event(cld_cmd_t'($urandom_range(0, 3)), $urandom_range(0, 4095));
                sent++;
            end
        end
    endtask

    task automatic random_config(int phase_no);
        int start;
        int stp;
        int rows;
        int cols;
        int tps;
        int pick;
        start = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 6) : $urandom_range(0, 1023);
        pick  = $urandom_range(0, 5);
        case (pick)
            0: stp = 0;
            1, 2: stp = 1;
            3: stp = 2;
            4: stp = 3;
            default: stp = $urandom_range(1, 255);
        endcase
        if (phase_no == 1)
            stp = 255;
        pick = $urandom_range(0, 99);
        rows = (pick < 8) ? 0 : (pick < 16) ? 127 : $urandom_range(1, 8);
        pick = $urandom_range(0, 99);
        cols = (pick < 8) ? 0 : (pick < 12) ? 256 : $urandom_range(1, 6);
        tps  = ($urandom_range(0, 99) < 5) ? 65535 : $urandom_range(0, 12);
        configure_all(start, stp, rows, cols, tps);
    endtask

    initial begin
        aresetn        <= 1'b0;
        s_valid        <= 1'b0;
        s_item         <= '0;
        psel           <= 1'b0;
        penable        <= 1'b0;
        pwrite         <= 1'b0;
        paddr          <= '0;
        pwdata         <= '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_pending   = 1'b0;
        sb             = new();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Short lines and rows: stray pixel, first row below start, hsync and vsync
        // during capture, zero ticks per second, and a full frame.
        set_idling(3);
        configure_all(1, 1, 2, 2, 0);
        push_event(CMD_PIXEL, 12'hFFF);
        push_event(CMD_TICK, 12'h000);
        push_event(CMD_VSYNC, 12'h000);
        push_event(CMD_HSYNC, 12'h000);
        push_event(CMD_HSYNC, 12'hFFF);
        push_event(CMD_PIXEL, 12'h000);
        push_event(CMD_HSYNC, 12'h000);
        push_event(CMD_PIXEL, 12'hFFF);
        push_event(CMD_PIXEL, 12'hAAA);
        push_event(CMD_PIXEL, 12'h555);
        push_event(CMD_HSYNC, 12'h000);
        push_event(CMD_PIXEL, 12'h123);
        push_event(CMD_VSYNC, 12'h000);
        push_event(CMD_TICK, 12'h000);
        push_event(CMD_HSYNC, 12'h000);
        send_line(2);
        send_line(2);
        push_event(CMD_HSYNC, 12'h000);
        push_event(CMD_PIXEL, 12'hEDC);
        wait_idle();

        // Row step changes mid-frame, zero step, zero row and column limits,
        // and the widest lines.
        set_idling(1);
        configure_all(0, 5, 127, 1, 65535);
        push_event(CMD_VSYNC, 12'h000);
        send_line(1);
        push_event(CMD_HSYNC, 12'h000);
        push_event(CMD_HSYNC, 12'h000);
        wait_idle();
        apb_write(REG_ROW_STEP, 2);
        send_line(1);
        wait_idle();
        apb_write(REG_ROW_STEP, 0);
        send_line(1);
        send_line(1);
        wait_idle();
        apb_write(REG_ROWS_TO_KEEP, 0);
        send_line(1);
        wait_idle();
        apb_write(REG_ROWS_TO_KEEP, 127);
        apb_write(REG_COLS_PER_ROW, 0);
        send_line(1);
        wait_idle();
        apb_write(REG_COLS_PER_ROW, 511);
        send_line(257);
        wait_idle();
        apb_write(REG_COLS_PER_ROW, 256);
        send_line(3);
        wait_idle();

        // Source row saturates at its maximum; then every kept row up to the limit.
        set_idling(2);
        configure_all(1023, 1, 127, 1, 7);
        push_event(CMD_VSYNC, 12'h000);
        repeat (1024) push_event(CMD_HSYNC, $urandom_range(0, 4095));
        repeat (66) send_line(1);
        wait_idle();

        // Random phases, cycling through the idling patterns.
        for (int p = 0; p < 8; p++) begin
            random_config(p);
            set_idling(p % 4);
            if (p == 0)
                hold_pending = 1'b1;
            run_random_phase(14);
            wait_idle();
        end

        // The per-second frame count saturates within one measurement window.
        set_idling(3);
        apb_write(REG_TICKS_PER_SEC, 65535);
        repeat (258) push_event(CMD_VSYNC, $urandom_range(0, 4095));
        wait_idle();
        apb_write(REG_TICKS_PER_SEC, 1);
        push_event(CMD_TICK, 12'h000);
        push_event(CMD_TICK, 12'h000);
        wait_idle();

        repeat (10) @(posedge aclk);
        if (sb.errors == 0)
            $display("camera_line_capture_decimator_tb OK");
        else
            $display("camera_line_capture_decimator_tb NOT OK");
        $finish;
    end

endmodule
